// ===== sv/ecp_pkg.sv =====
`timescale 1ns / 1ps

package ecp_pkg;

    localparam int WORD_W                = 32;
    localparam int SPEED_W               = 31;
    localparam int GAMMA_W               = 18;
    localparam int GAMMA_FRAC            = 16;
    localparam int FRACTION_BITS_DEFAULT = 16;

    // gamma = 1.4 in Q2.16
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_DENSITY  = 2'd1,
        STATUS_BAD_PRESSURE = 2'd2
    } status_t;

endpackage

// ===== sv/ecp_cons_if.sv =====
`timescale 1ns / 1ps

interface ecp_cons_if
    import ecp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] density;
    logic signed [WORD_W-1:0] momentum_x;
    logic signed [WORD_W-1:0] momentum_y;
    logic signed [WORD_W-1:0] total_energy;

    modport source (
        output valid, density, momentum_x, momentum_y, total_energy,
        input  ready
    );

    modport sink (
        input  valid, density, momentum_x, momentum_y, total_energy,
        output ready
    );
endinterface

// ===== sv/ecp_prim_if.sv =====
`timescale 1ns / 1ps

interface ecp_prim_if
    import ecp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] out_density;
    logic signed [WORD_W-1:0] velocity_x;
    logic signed [WORD_W-1:0] velocity_y;
    logic signed [WORD_W-1:0] pressure;
    logic [SPEED_W-1:0]       sonic_speed;
    status_t                  status;

    modport source (
        output valid, out_density, velocity_x, velocity_y, pressure, sonic_speed, status,
        input  ready
    );

    modport sink (
        input  valid, out_density, velocity_x, velocity_y, pressure, sonic_speed, status,
        output ready
    );
endinterface

// ===== sv/euler_conserved_to_primitive_top.sv =====
// channel | dir | words                                   | handshake
// cons    | in  | density, momentum_x/y, total_energy      | valid/ready
// prim    | out | density, velocities, pressure, c, status | valid/ready
// cfg     | in  | heat_capacity_ratio                      | cfg_we, no ready
//
// One word per cycle while prim is not stalled; the datapath is built from the radix-2
// divider rows (63 steps for u, v and kinetic energy, 2F+33 for c^2, F = FRACTION_BITS,
// 16 at Q16.16) and the 31-step square root row.
// Reset clears the valid bits and loads gamma = 1.4; payload flops are not reset.
// A stall on prim freezes every stage at once; cons.ready drops only while the
// output register holds a word that is not taken.
`timescale 1ns / 1ps

module euler_conserved_to_primitive_top
    import ecp_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [GAMMA_W-1:0] cfg_wdata,
    ecp_cons_if.sink           cons,
    ecp_prim_if.source         prim
);

    localparam int NA     = 2 * WORD_W - 1;
    localparam int SHIFT  = 2 * FRACTION_BITS - GAMMA_FRAC;
    localparam int NUM_W  = GAMMA_W + WORD_W - 1;
    localparam int NC     = NUM_W + SHIFT;
    localparam int CW     = (NC > 64) ? NC : 64;
    localparam int ND     = WORD_W - 1;
    localparam int PROD_W = 47 + GAMMA_W;

    typedef struct packed {
        logic [WORD_W-1:0] rho;
        logic [WORD_W-1:0] e;
        logic              mx_neg;
        logic              my_neg;
        logic              bad;
    } a_side_t;

    typedef struct packed {
        logic [WORD_W-1:0]  rho;
        logic [WORD_W-1:0]  u;
        logic [WORD_W-1:0]  v;
        logic [SPEED_W-1:0] p;
        status_t            status;
    } c_side_t;

    function automatic logic [WORD_W:0] div_step(
        input logic [WORD_W-1:0] rem,
        input logic              b,
        input logic [WORD_W-1:0] den
    );
        logic [WORD_W:0] t;
        logic [WORD_W:0] d;
        t = {rem, b};
        d = {1'b0, den};
        if (t >= d)
        begin
            return {1'b1, WORD_W'(t - d)};
        end
        return {1'b0, t[WORD_W-1:0]};
    endfunction

    function automatic logic [2*WORD_W-2:0] sqrt_step(
        input logic [WORD_W-1:0]  rem,
        input logic [1:0]         pair,
        input logic [SPEED_W-1:0] root
    );
        logic [WORD_W+1:0] t;
        logic [WORD_W+1:0] trial;
        t     = {rem, pair};
        trial = {1'b0, root, 2'b01};
        if (t >= trial)
        begin
            return {root[SPEED_W-2:0], 1'b1, WORD_W'(t - trial)};
        end
        return {root[SPEED_W-2:0], 1'b0, t[WORD_W-1:0]};
    endfunction

    function automatic logic [WORD_W-1:0] sat_quot(
        input logic [NA-1:0] q,
        input logic          neg
    );
        logic big;
        big = |q[NA-1:WORD_W-1];
        if (neg)
        begin
            return big ? {1'b1, {(WORD_W-1){1'b0}}} : (~q[WORD_W-1:0] + WORD_W'(1));
        end
        return big ? {1'b0, {(WORD_W-1){1'b1}}} : q[WORD_W-1:0];
    endfunction

    logic adv;
    logic [GAMMA_W-1:0] gamma_reg;

    // entry stage: magnitudes and squares
    logic [WORD_W-1:0]   mx_bits, my_bits, mxa, mya;
    logic [2*WORD_W-1:0] sqx_next, sqy_next;
    a_side_t             p_side_next;
    logic                p_vld_reg;
    a_side_t             p_side_reg;
    logic [WORD_W-1:0]   p_mxa_reg, p_mya_reg;
    logic [2*WORD_W-1:0] p_sqx_reg, p_sqy_reg;

    // divider row for u, v and kinetic energy
    logic              a_vld_reg  [0:NA];
    a_side_t           a_side_reg [0:NA];
    logic [WORD_W-1:0] a_ru_reg [0:NA], a_rv_reg [0:NA], a_rk_reg [0:NA];
    logic [NA-1:0]     a_nu_reg [0:NA], a_nv_reg [0:NA], a_nk_reg [0:NA];
    logic [WORD_W-1:0] a_ru_next [1:NA], a_rv_next [1:NA], a_rk_next [1:NA];
    logic [NA-1:0]     a_nu_next [1:NA], a_nv_next [1:NA], a_nk_next [1:NA];
    logic [2*WORD_W-1:0] sq_sum;

    // pressure stages
    logic                b1_vld_reg, b2_vld_reg, b3_vld_reg, b4_vld_reg;
    logic [WORD_W-1:0]   b1_u_reg, b1_v_reg, b2_u_reg, b2_v_reg, b3_u_reg, b3_v_reg;
    logic [WORD_W-1:0]   b4_u_reg, b4_v_reg;
    logic [WORD_W-1:0]   b1_rho_reg, b2_rho_reg, b3_rho_reg, b4_rho_reg;
    logic                b1_bad_reg, b2_bad_reg, b3_bad_reg;
    logic [2*WORD_W-1:0] b1_d_reg, b1_d_next;
    logic [GAMMA_W:0]    gm1;
    logic [GAMMA_W-1:0]  g_next;
    logic [2*WORD_W-2:0] mag_next;
    logic [46:0]         b2_mag_reg;
    logic [GAMMA_W-1:0]  b2_g_reg;
    logic                b2_big_reg, b2_magz_reg, b2_neg_reg, b2_gz_reg;
    logic [PROD_W-1:0]   b3_prod_reg;
    logic                b3_big_reg, b3_magz_reg, b3_neg_reg, b3_gz_reg;
    logic                pos_next;
    logic [SPEED_W-1:0]  p_next;
    status_t             status_next;
    logic [SPEED_W-1:0]  b4_p_reg;
    status_t             b4_status_reg;

    // divider row for c^2
    logic [NUM_W-1:0]  num_next;
    logic              c_vld_reg  [0:NC];
    c_side_t           c_side_reg [0:NC];
    logic [WORD_W-1:0] c_r_reg  [0:NC];
    logic [NC-1:0]     c_n_reg  [0:NC];
    logic [WORD_W-1:0] c_r_next [1:NC];
    logic [NC-1:0]     c_n_next [1:NC];

    // square root row
    logic [CW-1:0]      qx;
    logic               d_vld_reg  [0:ND];
    c_side_t            d_side_reg [0:ND];
    logic               d_sat_reg  [0:ND];
    logic [WORD_W-1:0]  d_r_reg    [0:ND];
    logic [SPEED_W-1:0] d_root_reg [0:ND];
    logic [61:0]        d_rad_reg  [0:ND];
    logic [WORD_W-1:0]  d_r_next    [1:ND];
    logic [SPEED_W-1:0] d_root_next [1:ND];
    logic [61:0]        d_rad_next  [1:ND];

    // output register
    logic               o_vld_reg;
    logic [WORD_W-1:0]  o_rho_reg, o_u_reg, o_v_reg, o_p_reg;
    logic [SPEED_W-1:0] o_c_reg;
    status_t            o_status_reg;
    c_side_t            o_side;
    logic [SPEED_W-1:0] o_c_next;

    assign adv        = !o_vld_reg || prim.ready;
    assign cons.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RESET;
        end
        else if (cfg_we)
        begin
            gamma_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        mx_bits = cons.momentum_x;
        my_bits = cons.momentum_y;
        mxa     = mx_bits[WORD_W-1] ? (~mx_bits + WORD_W'(1)) : mx_bits;
        mya     = my_bits[WORD_W-1] ? (~my_bits + WORD_W'(1)) : my_bits;
        sqx_next = (2*WORD_W)'(mxa) * (2*WORD_W)'(mxa);
        sqy_next = (2*WORD_W)'(mya) * (2*WORD_W)'(mya);
        p_side_next.rho    = cons.density;
        p_side_next.e      = cons.total_energy;
        p_side_next.mx_neg = mx_bits[WORD_W-1];
        p_side_next.my_neg = my_bits[WORD_W-1];
        p_side_next.bad    = cons.density[WORD_W-1] || (cons.density == '0);
        sq_sum = p_sqx_reg + p_sqy_reg;
    end

    // kinetic row divides half the square sum by rho, same floor as sum / (2 rho)
    always_comb
    begin
        logic [WORD_W:0] su, sv, sk;
        for (int j = 0; j < NA; j++)
        begin
            su = div_step(a_ru_reg[j], a_nu_reg[j][NA-1],
                          {1'b0, a_side_reg[j].rho[WORD_W-2:0]});
            sv = div_step(a_rv_reg[j], a_nv_reg[j][NA-1],
                          {1'b0, a_side_reg[j].rho[WORD_W-2:0]});
            sk = div_step(a_rk_reg[j], a_nk_reg[j][NA-1],
                          {1'b0, a_side_reg[j].rho[WORD_W-2:0]});
            a_ru_next[j+1] = su[WORD_W-1:0];
            a_rv_next[j+1] = sv[WORD_W-1:0];
            a_rk_next[j+1] = sk[WORD_W-1:0];
            a_nu_next[j+1] = {a_nu_reg[j][NA-2:0], su[WORD_W]};
            a_nv_next[j+1] = {a_nv_reg[j][NA-2:0], sv[WORD_W]};
            a_nk_next[j+1] = {a_nk_reg[j][NA-2:0], sk[WORD_W]};
        end
    end

    always_comb
    begin
        b1_d_next = {{WORD_W{a_side_reg[NA].e[WORD_W-1]}}, a_side_reg[NA].e}
                    - {1'b0, a_nk_reg[NA]};
        mag_next  = b1_d_reg[2*WORD_W-1] ? (2*WORD_W-1)'(~b1_d_reg + (2*WORD_W)'(1))
                                         : b1_d_reg[2*WORD_W-2:0];
        gm1       = {1'b0, gamma_reg} - (GAMMA_W+1)'(65536);
        g_next    = gm1[GAMMA_W] ? GAMMA_W'(~gm1 + (GAMMA_W+1)'(1)) : gm1[GAMMA_W-1:0];
        // saturate once the product reaches 2^47, i.e. the quotient reaches 2^31
        pos_next  = !b3_neg_reg && !b3_magz_reg && !b3_gz_reg
                    && (b3_big_reg || (|b3_prod_reg[PROD_W-1:16]));
        p_next    = (b3_big_reg || (|b3_prod_reg[PROD_W-1:47])) ? {SPEED_W{1'b1}}
                                                                  : b3_prod_reg[46:16];
        priority if (b3_bad_reg)
        begin
            status_next = STATUS_BAD_DENSITY;
        end
        else if (!pos_next)
        begin
            status_next = STATUS_BAD_PRESSURE;
        end
        else
        begin
            status_next = STATUS_OK;
        end
        num_next = NUM_W'(gamma_reg) * NUM_W'(b4_p_reg);
    end

    always_comb
    begin
        logic [WORD_W:0] sc;
        for (int j = 0; j < NC; j++)
        begin
            sc = div_step(c_r_reg[j], c_n_reg[j][NC-1],
                          {1'b0, c_side_reg[j].rho[WORD_W-2:0]});
            c_r_next[j+1] = sc[WORD_W-1:0];
            c_n_next[j+1] = {c_n_reg[j][NC-2:0], sc[WORD_W]};
        end
        qx = CW'(c_n_reg[NC]);
    end

    always_comb
    begin
        logic [2*WORD_W-2:0] sr;
        for (int j = 0; j < ND; j++)
        begin
            sr = sqrt_step(d_r_reg[j], d_rad_reg[j][61:60], d_root_reg[j]);
            d_root_next[j+1] = sr[2*WORD_W-2:WORD_W];
            d_r_next[j+1]    = sr[WORD_W-1:0];
            d_rad_next[j+1]  = {d_rad_reg[j][59:0], 2'b00};
        end
        o_side   = d_side_reg[ND];
        o_c_next = d_sat_reg[ND] ? {SPEED_W{1'b1}} : d_root_reg[ND];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg  <= 1'b0;
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
            b4_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
            for (int j = 0; j <= NA; j++)
            begin
                a_vld_reg[j] <= 1'b0;
            end
            for (int j = 0; j <= NC; j++)
            begin
                c_vld_reg[j] <= 1'b0;
            end
            for (int j = 0; j <= ND; j++)
            begin
                d_vld_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            p_vld_reg    <= cons.valid;
            a_vld_reg[0] <= p_vld_reg;
            for (int j = 1; j <= NA; j++)
            begin
                a_vld_reg[j] <= a_vld_reg[j-1];
            end
            b1_vld_reg   <= a_vld_reg[NA];
            b2_vld_reg   <= b1_vld_reg;
            b3_vld_reg   <= b2_vld_reg;
            b4_vld_reg   <= b3_vld_reg;
            c_vld_reg[0] <= b4_vld_reg;
            for (int j = 1; j <= NC; j++)
            begin
                c_vld_reg[j] <= c_vld_reg[j-1];
            end
            d_vld_reg[0] <= c_vld_reg[NC];
            for (int j = 1; j <= ND; j++)
            begin
                d_vld_reg[j] <= d_vld_reg[j-1];
            end
            o_vld_reg    <= d_vld_reg[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_side_reg <= p_side_next;
            p_mxa_reg  <= mxa;
            p_mya_reg  <= mya;
            p_sqx_reg  <= sqx_next;
            p_sqy_reg  <= sqy_next;

            a_side_reg[0] <= p_side_reg;
            a_ru_reg[0]   <= '0;
            a_rv_reg[0]   <= '0;
            a_rk_reg[0]   <= '0;
            a_nu_reg[0]   <= NA'(p_mxa_reg) << FRACTION_BITS;
            a_nv_reg[0]   <= NA'(p_mya_reg) << FRACTION_BITS;
            a_nk_reg[0]   <= sq_sum[2*WORD_W-1:1];
            for (int j = 1; j <= NA; j++)
            begin
                a_side_reg[j] <= a_side_reg[j-1];
                a_ru_reg[j]   <= a_ru_next[j];
                a_rv_reg[j]   <= a_rv_next[j];
                a_rk_reg[j]   <= a_rk_next[j];
                a_nu_reg[j]   <= a_nu_next[j];
                a_nv_reg[j]   <= a_nv_next[j];
                a_nk_reg[j]   <= a_nk_next[j];
            end

            b1_u_reg   <= sat_quot(a_nu_reg[NA], a_side_reg[NA].mx_neg);
            b1_v_reg   <= sat_quot(a_nv_reg[NA], a_side_reg[NA].my_neg);
            b1_d_reg   <= b1_d_next;
            b1_rho_reg <= a_side_reg[NA].rho;
            b1_bad_reg <= a_side_reg[NA].bad;

            b2_u_reg    <= b1_u_reg;
            b2_v_reg    <= b1_v_reg;
            b2_rho_reg  <= b1_rho_reg;
            b2_bad_reg  <= b1_bad_reg;
            b2_mag_reg  <= mag_next[46:0];
            b2_big_reg  <= |mag_next[2*WORD_W-2:47];
            b2_magz_reg <= (mag_next == '0);
            b2_neg_reg  <= b1_d_reg[2*WORD_W-1] ^ gm1[GAMMA_W];
            b2_g_reg    <= g_next;
            b2_gz_reg   <= (g_next == '0);

            b3_u_reg    <= b2_u_reg;
            b3_v_reg    <= b2_v_reg;
            b3_rho_reg  <= b2_rho_reg;
            b3_bad_reg  <= b2_bad_reg;
            b3_prod_reg <= PROD_W'(b2_mag_reg) * PROD_W'(b2_g_reg);
            b3_big_reg  <= b2_big_reg;
            b3_magz_reg <= b2_magz_reg;
            b3_neg_reg  <= b2_neg_reg;
            b3_gz_reg   <= b2_gz_reg;

            b4_u_reg      <= b3_u_reg;
            b4_v_reg      <= b3_v_reg;
            b4_rho_reg    <= b3_rho_reg;
            b4_p_reg      <= p_next;
            b4_status_reg <= status_next;

            c_side_reg[0].rho    <= b4_rho_reg;
            c_side_reg[0].u      <= b4_u_reg;
            c_side_reg[0].v      <= b4_v_reg;
            c_side_reg[0].p      <= b4_p_reg;
            c_side_reg[0].status <= b4_status_reg;
            c_r_reg[0]           <= '0;
            c_n_reg[0]           <= NC'(num_next) << SHIFT;
            for (int j = 1; j <= NC; j++)
            begin
                c_side_reg[j] <= c_side_reg[j-1];
                c_r_reg[j]    <= c_r_next[j];
                c_n_reg[j]    <= c_n_next[j];
            end

            // c^2 at or above 2^62 pins the root to full scale
            d_side_reg[0] <= c_side_reg[NC];
            d_sat_reg[0]  <= |qx[CW-1:62];
            d_r_reg[0]    <= '0;
            d_root_reg[0] <= '0;
            d_rad_reg[0]  <= qx[61:0];
            for (int j = 1; j <= ND; j++)
            begin
                d_side_reg[j] <= d_side_reg[j-1];
                d_sat_reg[j]  <= d_sat_reg[j-1];
                d_r_reg[j]    <= d_r_next[j];
                d_root_reg[j] <= d_root_next[j];
                d_rad_reg[j]  <= d_rad_next[j];
            end

            o_status_reg <= o_side.status;
            if (o_side.status == STATUS_OK)
            begin
                o_rho_reg <= o_side.rho;
                o_u_reg   <= o_side.u;
                o_v_reg   <= o_side.v;
                o_p_reg   <= {1'b0, o_side.p};
                o_c_reg   <= o_c_next;
            end
            else
            begin
                o_rho_reg <= '0;
                o_u_reg   <= '0;
                o_v_reg   <= '0;
                o_p_reg   <= '0;
                o_c_reg   <= '0;
            end
        end
    end

    assign prim.valid       = o_vld_reg;
    assign prim.out_density = o_rho_reg;
    assign prim.velocity_x  = o_u_reg;
    assign prim.velocity_y  = o_v_reg;
    assign prim.pressure    = o_p_reg;
    assign prim.sonic_speed = o_c_reg;
    assign prim.status      = o_status_reg;

endmodule

// ===== sv/ecp_checker.sv =====
`timescale 1ns / 1ps

module ecp_checker
    import ecp_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cons_valid,
    input logic                     cons_ready,
    input logic                     prim_valid,
    input logic                     prim_ready,
    input logic signed [WORD_W-1:0] prim_density,
    input logic signed [WORD_W-1:0] prim_vx,
    input logic signed [WORD_W-1:0] prim_vy,
    input logic signed [WORD_W-1:0] prim_pressure,
    input logic [SPEED_W-1:0]       prim_speed,
    input status_t                  prim_status
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        prim_valid && !prim_ready |=>
            prim_valid && $stable(prim_pressure) && $stable(prim_status))
        else $error("result word changed while stalled");

    // an empty output register never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !prim_valid |-> cons_ready)
        else $error("input blocked with empty output");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        prim_valid && prim_status != STATUS_OK |->
            prim_density == 0 && prim_vx == 0 && prim_vy == 0
            && prim_pressure == 0 && prim_speed == 0)
        else $error("fault word carries nonzero fields");

    a_ok_positive: assert property (@(posedge clk) disable iff (!rst_n)
        prim_valid && prim_status == STATUS_OK |->
            prim_density > 0 && prim_pressure > 0)
        else $error("ok word with non-positive density or pressure");

endmodule

bind euler_conserved_to_primitive_top ecp_checker u_ecp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cons_valid    (cons.valid),
    .cons_ready    (cons.ready),
    .prim_valid    (prim.valid),
    .prim_ready    (prim.ready),
    .prim_density  (prim.out_density),
    .prim_vx       (prim.velocity_x),
    .prim_vy       (prim.velocity_y),
    .prim_pressure (prim.pressure),
    .prim_speed    (prim.sonic_speed),
    .prim_status   (prim.status)
);

// ===== verif/euler_conserved_to_primitive_top_tb.sv =====
`timescale 1ns / 1ps

module euler_conserved_to_primitive_top_tb;
    import ecp_pkg::*;

    localparam int  LATENCY     = 2 * FRACTION_BITS_DEFAULT + 135;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  HOLD_CYCLES = 600;
    localparam logic signed [WORD_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] ONE   = 32'sd65536;

    typedef struct packed {
        logic signed [WORD_W-1:0] dens;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
        logic signed [WORD_W-1:0] pres;
        logic [SPEED_W-1:0]       speed;
        status_t                  st;
    } prim_word_t;

    typedef struct {
        logic signed [WORD_W-1:0] rho;
        logic signed [WORD_W-1:0] mx;
        logic signed [WORD_W-1:0] my;
        logic signed [WORD_W-1:0] e;
        bit                       typed;
        prim_word_t               want;
    } cell_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [GAMMA_W-1:0] cfg_wdata;

    ecp_cons_if cons_w ();
    ecp_prim_if prim_w ();

    euler_conserved_to_primitive_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cons      (cons_w),
        .prim      (prim_w)
    );

    always #5 clk = ~clk;

    prim_word_t primitive_q[$];
    logic [GAMMA_W-1:0] gamma_now;
    int errors = 0;
    int cycles = 0;
    int src_idle = 23;
    int rcv_idle = 57;
    logic hold_go;
    int hold_left = HOLD_CYCLES;
    cell_row_t rows[$];

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned root, bit_v;
        root  = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (n >= root + bit_v)
            begin
                n    = n - (root + bit_v);
                root = (root >> 1) + bit_v;
            end
            else
            begin
                root = root >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return root;
    endfunction

    function automatic longint sat_word(input longint x);
        if (x > longint'(S_MAX)) return longint'(S_MAX);
        if (x < longint'(S_MIN)) return longint'(S_MIN);
        return x;
    endfunction

    function automatic longint unsigned mag(input longint x);
        return (x < 0) ? 64'd0 - longint'(x) : longint'(x);
    endfunction

    function automatic prim_word_t to_primitive(input logic signed [WORD_W-1:0] rho_i,
                                                input logic signed [WORD_W-1:0] mx_i,
                                                input logic signed [WORD_W-1:0] my_i,
                                                input logic signed [WORD_W-1:0] e_i,
                                                input logic [GAMMA_W-1:0] g_i);
        prim_word_t w;
        longint rho, mx, my, u, v, d, gm1, p;
        longint unsigned sq, kin, md, g, q, num, q1, r, c;
        bit neg;
        w   = '0;
        w.st = STATUS_OK;
        rho = rho_i;
        mx  = mx_i;
        my  = my_i;
        if (rho <= 0)
        begin
            w.st = STATUS_BAD_DENSITY;
            return w;
        end
        u   = sat_word((mx * 65536) / rho);
        v   = sat_word((my * 65536) / rho);
        sq  = mag(mx) * mag(mx) + mag(my) * mag(my);
        kin = sq / (2 * longint'(rho));
        d   = longint'(e_i) - longint'(kin);
        gm1 = longint'(g_i) - 65536;
        md  = mag(d);
        g   = mag(gm1);
        neg = (d < 0) != (gm1 < 0);
        if (g == 0 || md == 0)
        begin
            p = 0;
        end
        else if (md > (64'd1 << 62) / g)
        begin
            p = neg ? longint'(S_MIN) : longint'(S_MAX);
        end
        else
        begin
            q = (md * g) >> GAMMA_FRAC;
            if (q > 64'h7FFF_FFFF) p = neg ? longint'(S_MIN) : longint'(S_MAX);
            else p = neg ? -longint'(q) : longint'(q);
        end
        if (p <= 0)
        begin
            w.st = STATUS_BAD_PRESSURE;
            return w;
        end
        num = longint'(g_i) * p;
        q1  = num / rho;
        r   = num % rho;
        if ((q1 >> 46) != 0)
        begin
            c = 64'h7FFF_FFFF;
        end
        else
        begin
            c = isqrt((q1 << 16) + ((r << 16) / rho));
            if (c > 64'h7FFF_FFFF) c = 64'h7FFF_FFFF;
        end
        w.dens  = rho_i;
        w.vel_x = u[31:0];
        w.vel_y = v[31:0];
        w.pres  = p[31:0];
        w.speed = c[30:0];
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // receiver: stall, long hold-off and result check
    always @(posedge clk)
    begin
        prim_word_t w;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            if (hold_go && hold_left > 0)
            begin
                prim_w.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end
            else
            begin
                prim_w.ready <= ($urandom_range(0, 99) >= rcv_idle);
            end
            if (rst_n && prim_w.valid && prim_w.ready)
            begin
                if (primitive_q.size() == 0)
                begin
                    report_mismatch("unexpected word", prim_w.out_density, 0);
                end
                else
                begin
                    w = primitive_q.pop_front();
                    if (prim_w.out_density !== w.dens)
                        report_mismatch("out_density", prim_w.out_density, w.dens);
                    if (prim_w.velocity_x !== w.vel_x)
                        report_mismatch("velocity_x", prim_w.velocity_x, w.vel_x);
                    if (prim_w.velocity_y !== w.vel_y)
                        report_mismatch("velocity_y", prim_w.velocity_y, w.vel_y);
                    if (prim_w.pressure !== w.pres)
                        report_mismatch("pressure", prim_w.pressure, w.pres);
                    if (prim_w.sonic_speed !== w.speed)
                        report_mismatch("sonic_speed", prim_w.sonic_speed, w.speed);
                    if (prim_w.status !== w.st)
                        report_mismatch("status", prim_w.status, w.st);
                end
            end
        end
    end

    task automatic offer_cell(input logic signed [WORD_W-1:0] rho,
                              input logic signed [WORD_W-1:0] mx,
                              input logic signed [WORD_W-1:0] my,
                              input logic signed [WORD_W-1:0] e,
                              input bit typed, input prim_word_t want);
        while ($urandom_range(0, 99) < src_idle)
        begin
            cons_w.valid <= 1'b0;
            @(posedge clk);
        end
        cons_w.valid        <= 1'b1;
        cons_w.density      <= rho;
        cons_w.momentum_x   <= mx;
        cons_w.momentum_y   <= my;
        cons_w.total_energy <= e;
        @(posedge clk);
        while (!cons_w.ready) @(posedge clk);
        primitive_q.push_back(typed ? want : to_primitive(rho, mx, my, e, gamma_now));
    endtask

    task automatic write_gamma(input logic [GAMMA_W-1:0] g);
        // drain the pipe before touching gamma
        while (primitive_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gamma_now  = g;
    endtask

    function automatic logic signed [WORD_W-1:0] edge_word();
        case ($urandom_range(0, 5))
            0: return 32'sd0;
            1: return 32'sd1;
            2: return -32'sd1;
            3: return S_MAX;
            4: return S_MIN;
            default: return ONE;
        endcase
    endfunction

    task automatic add_row(input logic signed [WORD_W-1:0] rho,
                           input logic signed [WORD_W-1:0] mx,
                           input logic signed [WORD_W-1:0] my,
                           input logic signed [WORD_W-1:0] e,
                           input bit typed, input prim_word_t want);
        cell_row_t c;
        c.rho   = rho;
        c.mx    = mx;
        c.my    = my;
        c.e     = e;
        c.typed = typed;
        c.want  = want;
        rows.push_back(c);
    endtask

    initial
    begin
        prim_word_t z, w;
        logic signed [WORD_W-1:0] rho, mx, my, e;
        logic [GAMMA_W-1:0] gammas[9];
        int k;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        hold_go      = 1'b0;
        cons_w.valid = 1'b0;
        cons_w.density      = '0;
        cons_w.momentum_x   = '0;
        cons_w.momentum_y   = '0;
        cons_w.total_energy = '0;
        gamma_now    = GAMMA_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        z    = '0;
        z.st = STATUS_BAD_DENSITY;
        add_row(32'sd0, ONE, ONE, ONE, 1, z);
        add_row(-32'sd1, S_MAX, S_MIN, S_MAX, 1, z);
        add_row(S_MIN, 32'sd0, 32'sd0, 32'sd0, 1, z);
        z.st = STATUS_BAD_PRESSURE;
        add_row(ONE, 32'sd0, 32'sd0, 32'sd0, 1, z);
        add_row(ONE, 32'sd0, 32'sd0, S_MIN, 1, z);
        add_row(ONE, 32'sd0, 32'sd0, -32'sd1, 1, z);
        // unit cell at rest with gamma 1.4
        w       = '0;
        w.dens  = ONE;
        w.pres  = 32'sd26214;
        w.speed = 31'd49042;
        w.st    = STATUS_OK;
        add_row(ONE, 32'sd0, 32'sd0, ONE, 1, w);
        add_row(32'sd1, S_MAX, S_MIN, S_MAX, 0, z);
        add_row(32'sd1, 32'sd0, 32'sd0, S_MAX, 0, z);
        add_row(S_MAX, S_MAX, S_MAX, S_MAX, 0, z);
        add_row(S_MAX, S_MIN, S_MIN, S_MAX, 0, z);
        add_row(ONE, S_MAX, 32'sd0, S_MAX, 0, z);
        add_row(ONE, S_MIN, S_MAX, S_MAX, 0, z);
        add_row(ONE, -ONE, ONE, S_MAX, 0, z);
        add_row(32'sd3, 32'sd7, -32'sd5, 32'sd1000, 0, z);
        add_row(ONE, ONE, ONE, ONE, 0, z);
        add_row(32'sd1, 32'sd1, 32'sd1, 32'sd1, 0, z);
        add_row(ONE, 32'sd0, 32'sd0, 32'sd1, 0, z);
        add_row(32'sd1, S_MIN, S_MIN, S_MAX, 0, z);
        add_row(S_MAX, S_MIN, S_MIN, S_MIN, 0, z);
        foreach (rows[i])
            offer_cell(rows[i].rho, rows[i].mx, rows[i].my, rows[i].e, rows[i].typed,
                       rows[i].want);
        cons_w.valid <= 1'b0;

        gammas = '{18'd91750, 18'd65537, 18'd196608, 18'd262143, 18'd0,
                   18'd65536, 18'd1000, 18'd120000, 18'd0};
        gammas[8] = $urandom_range(0, 262143);
        for (int ph = 0; ph < 9; ph++)
        begin
            write_gamma(gammas[ph]);
            src_idle = (ph < 3) ? 23 : (ph < 6) ? 57 : 0;
            rcv_idle = (ph < 3) ? 57 : (ph < 6) ? 23 : 0;
            if (ph == 6) hold_go <= 1'b1;
            repeat (170)
            begin
                k = $urandom_range(0, 99);
                if (k < 65)
                begin
                    rho = $urandom_range(1 << 10, 1 << 22);
                    mx  = $urandom_range(0, 1 << 22) - (1 << 21);
                    my  = $urandom_range(0, 1 << 22) - (1 << 21);
                    e   = $urandom_range(0, 1 << 30);
                end
                else if (k < 78)
                begin
                    rho = $urandom;
                    mx  = $urandom;
                    my  = $urandom;
                    e   = $urandom;
                end
                else if (k < 86)
                begin
                    rho = $urandom_range(0, 1) ? 32'sd0 : ($urandom | 32'h8000_0000);
                    mx  = $urandom;
                    my  = $urandom;
                    e   = $urandom;
                end
                else
                begin
                    rho = edge_word();
                    mx  = edge_word();
                    my  = edge_word();
                    e   = edge_word();
                end
                offer_cell(rho, mx, my, e, 0, z);
            end
            cons_w.valid <= 1'b0;
        end

        while (primitive_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ecp_pkg.sv
sv/ecp_cons_if.sv
sv/ecp_prim_if.sv
sv/euler_conserved_to_primitive_top.sv
sv/ecp_checker.sv
verif/euler_conserved_to_primitive_top_tb.sv
